// ----- hdl/itf_pkg.sv -----
// Shared types, constants and helpers for the integer text formatter.
// Used by itf_digit_unit, itf_emitter and integer_text_formatter_core.
package itf_pkg;

  // Output limit: at most OUT_LIMIT-1 characters are emitted per value
  localparam int OUT_LIMIT  = 50;
  localparam int TEXT_LIMIT = OUT_LIMIT - 1;

  // Fixed field widths
  localparam int VAL_W  = 32;
  localparam int FW_W   = 6;
  localparam int CHAR_W = 8;
  localparam int MODE_W = 2;
  localparam int DIG_W  = 4;

  // Digit buffer: 32-bit octal needs eleven digits
  localparam int DIGIT_MAX = 11;
  localparam int DADDR_W   = $clog2(DIGIT_MAX);
  localparam int DCNT_W    = $clog2(DIGIT_MAX + 1);

  // Emitted length and position widths
  localparam int LEN_W = $clog2(OUT_LIMIT);
  localparam int POS_W = ((FW_W > LEN_W) ? FW_W : LEN_W) + 1;

  // Divide by ten: q = (x * RECIP10) >> RECIP_SHIFT, exact for 32-bit x
  localparam logic [VAL_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_OCT
  } base_e;

  typedef enum logic [1:0] {
    LAY_LEFT,
    LAY_ZERO,
    LAY_RIGHT
  } layout_e;

  typedef enum logic [1:0] {
    DU_IDLE,
    DU_MUL,
    DU_DIV
  } du_state_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_CONV,
    CTL_EMIT
  } ctl_state_e;

  // Digit write from the divider into the digit buffer
  typedef struct packed {
    logic               en;
    logic [DADDR_W-1:0] addr;
    logic [DIG_W-1:0]   digit;
  } dig_wr_t;

  // Run description handed to the emitter
  typedef struct packed {
    logic              has_sign;
    logic [CHAR_W-1:0] sign_char;
    logic [CHAR_W-1:0] fill_char;
    logic [POS_W-1:0]  sign_pos;
    logic [POS_W-1:0]  dig_lo;
    logic [DCNT_W-1:0] nd;
    logic [LEN_W-1:0]  len;
  } emit_cfg_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

// ----- hdl/itf_digit_unit.sv -----
// Shared divider: peels one digit per step off the magnitude, least
// significant first. Depends on itf_pkg.
module itf_digit_unit import itf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  base_e             base_i,
  input  logic [VAL_W-1:0]  mag_i,
  output dig_wr_t           wr_o,
  output logic              done_o,
  output logic [DCNT_W-1:0] nd_o
);

  du_state_e state_q, state_d;

  logic [VAL_W-1:0]   mag_q;
  base_e              base_q;
  logic [2*VAL_W-1:0] prod_q;
  logic [DCNT_W-1:0]  cnt_q;

  logic [VAL_W-1:0] quo;
  logic [VAL_W-1:0] diff;
  logic [DIG_W-1:0] rem;
  logic             finish;

  // Quotient and remainder for the current base
  always_comb begin
    quo  = '0;
    diff = '0;
    rem  = '0;
    unique case (base_q)
      BASE_HEX: begin
        quo = mag_q >> 4;
        rem = mag_q[3:0];
      end
      BASE_OCT: begin
        quo = mag_q >> 3;
        rem = {1'b0, mag_q[2:0]};
      end
      default: begin
        quo  = VAL_W'(prod_q >> RECIP_SHIFT);
        diff = mag_q - (quo << 3) - (quo << 1);
        rem  = diff[DIG_W-1:0];
      end
    endcase
  end

  assign finish = (quo == '0) || (cnt_q == DCNT_W'(DIGIT_MAX - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DU_IDLE: if (go_i) state_d = DU_MUL;
      DU_MUL:  state_d = DU_DIV;
      DU_DIV:  state_d = finish ? DU_IDLE : DU_MUL;
      default: state_d = DU_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    wr_o.en    = (state_q == DU_DIV);
    wr_o.addr  = cnt_q[DADDR_W-1:0];
    wr_o.digit = rem;
    done_o     = (state_q == DU_DIV) && finish;
    nd_o       = cnt_q + DCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Load the operand, multiply by the reciprocal, then advance the quotient
  always_ff @(posedge clk_i) begin
    case (state_q)
      DU_IDLE: begin
        if (go_i) begin
          mag_q  <= mag_i;
          base_q <= base_i;
          cnt_q  <= '0;
        end
      end
      DU_MUL: begin
        prod_q <= {{VAL_W{1'b0}}, mag_q} * {{VAL_W{1'b0}}, RECIP10};
      end
      DU_DIV: begin
        mag_q <= quo;
        cnt_q <= cnt_q + DCNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/itf_emitter.sv -----
// Digit buffer and character emitter: one character per cycle with a
// last mark. Depends on itf_pkg.
module itf_emitter import itf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dig_wr_t           wr_i,
  input  logic              go_i,
  input  emit_cfg_t         cfg_i,
  output logic              strobe_o,
  output logic [CHAR_W-1:0] char_o,
  output logic              last_o
);

  logic [DIG_W-1:0] dig_buf [DIGIT_MAX];

  emit_cfg_t        cfg_q;
  logic             run_q;
  logic [LEN_W-1:0] pos_q;

  logic              strobe_q;
  logic              last_q;
  logic [CHAR_W-1:0] char_q;

  logic [POS_W-1:0]   pos_ext;
  logic [POS_W-1:0]   dig_hi;
  logic [POS_W-1:0]   dofs;
  logic [POS_W-1:0]   raddr_full;
  logic [DADDR_W-1:0] raddr;
  logic               in_dig;
  logic               at_sign;
  logic               at_last;
  logic [CHAR_W-1:0]  char_d;

  // Store digits as the divider produces them
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      dig_buf[wr_i.addr] <= wr_i.digit;
    end
  end

  // Pick the character for the current position
  always_comb begin
    pos_ext    = POS_W'(pos_q);
    dig_hi     = cfg_q.dig_lo + POS_W'(cfg_q.nd);
    in_dig     = (pos_ext >= cfg_q.dig_lo) && (pos_ext < dig_hi);
    at_sign    = cfg_q.has_sign && (pos_ext == cfg_q.sign_pos);
    dofs       = pos_ext - cfg_q.dig_lo;
    raddr_full = POS_W'(cfg_q.nd) - POS_W'(1) - dofs;
    raddr      = raddr_full[DADDR_W-1:0];
    if (at_sign) begin
      char_d = cfg_q.sign_char;
    end else if (in_dig) begin
      char_d = digit_char(dig_buf[raddr]);
    end else begin
      char_d = cfg_q.fill_char;
    end
    at_last = (pos_q == cfg_q.len - LEN_W'(1));
  end

  // Run control and output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= run_q;
      last_q   <= run_q && at_last;
      if (go_i) begin
        run_q <= 1'b1;
        pos_q <= '0;
      end else if (run_q) begin
        pos_q <= pos_q + LEN_W'(1);
        if (at_last) run_q <= 1'b0;
      end
    end
  end

  // Hold the run description and the character register
  always_ff @(posedge clk_i) begin
    if (go_i) cfg_q <= cfg_i;
    char_q <= char_d;
  end

  assign strobe_o = strobe_q;
  assign char_o   = char_q;
  assign last_o   = last_q;

endmodule

// ----- hdl/integer_text_formatter_core.sv -----
// Integer text formatter, top level: printf-style %d %u %x %o text.
// The first character waits for the conversion of all N digits (1..11), each made
// by the shared divide step (multiply, then reduce), and then for the emitter.
// A new value waits for the last character; L characters (1..49) leave at one a cycle.
// Characters leave on strobe_o for one cycle each; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns to idle and drops any run.
module integer_text_formatter_core import itf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [FW_W-1:0]   field_width_i,
  input  logic              left_justify_i,
  input  logic              force_plus_i,
  input  logic              zero_fill_i,
  output logic              strobe_o,
  output logic [CHAR_W-1:0] text_char_o,
  output logic              last_o
);

  ctl_state_e state_q, state_d;

  logic      accept;
  logic      neg_in;
  logic [VAL_W-1:0] mag_in;
  base_e     base_in;

  logic      has_sign_q;
  logic      neg_q;
  logic      dec_q;
  logic [FW_W-1:0] fw_q;
  layout_e   layout_q;

  dig_wr_t           dig_wr;
  logic              du_done;
  logic [DCNT_W-1:0] du_nd;

  logic [POS_W-1:0] body;
  logic [POS_W-1:0] fw_ext;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] total;
  emit_cfg_t        cfg;

  assign accept = start && !busy;

  // Magnitude and base of the incoming request
  always_comb begin
    neg_in = (mode_e'(mode_i) == MODE_SDEC) && value_i[VAL_W-1];
    mag_in = neg_in ? (~value_i + VAL_W'(1)) : value_i;
    unique case (mode_e'(mode_i))
      MODE_HEX: base_in = BASE_HEX;
      MODE_OCT: base_in = BASE_OCT;
      default:  base_in = BASE_DEC;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTL_IDLE: if (accept) state_d = CTL_CONV;
      CTL_CONV: if (du_done) state_d = CTL_EMIT;
      CTL_EMIT: if (strobe_o && last_o) state_d = CTL_IDLE;
      default:  state_d = CTL_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    busy = (state_q != CTL_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request's flags
  always_ff @(posedge clk_i) begin
    if (accept) begin
      has_sign_q <= (mode_e'(mode_i) == MODE_SDEC) && (value_i[VAL_W-1] || force_plus_i);
      neg_q      <= neg_in;
      dec_q      <= (mode_e'(mode_i) == MODE_SDEC) || (mode_e'(mode_i) == MODE_UDEC);
      fw_q       <= field_width_i;
      if (left_justify_i)   layout_q <= LAY_LEFT;
      else if (zero_fill_i) layout_q <= LAY_ZERO;
      else                  layout_q <= LAY_RIGHT;
    end
  end

  // Work out padding, length and the placement of sign and digits
  always_comb begin
    body   = POS_W'(du_nd) + POS_W'(has_sign_q);
    fw_ext = POS_W'(fw_q);
    pad    = (dec_q && (fw_ext > body)) ? (fw_ext - body) : '0;
    total  = pad + body;
    cfg.has_sign  = has_sign_q;
    cfg.sign_char = neg_q ? CH_MINUS : CH_PLUS;
    cfg.nd        = du_nd;
    cfg.len       = (total > POS_W'(TEXT_LIMIT)) ? LEN_W'(TEXT_LIMIT) : LEN_W'(total);
    unique case (layout_q)
      LAY_LEFT: begin
        cfg.fill_char = CH_SPACE;
        cfg.sign_pos  = '0;
        cfg.dig_lo    = POS_W'(has_sign_q);
      end
      LAY_ZERO: begin
        cfg.fill_char = CH_ZERO;
        cfg.sign_pos  = '0;
        cfg.dig_lo    = pad + POS_W'(has_sign_q);
      end
      default: begin
        cfg.fill_char = CH_SPACE;
        cfg.sign_pos  = pad;
        cfg.dig_lo    = pad + POS_W'(has_sign_q);
      end
    endcase
  end

  itf_digit_unit u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept),
    .base_i (base_in),
    .mag_i  (mag_in),
    .wr_o   (dig_wr),
    .done_o (du_done),
    .nd_o   (du_nd)
  );

  itf_emitter u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (dig_wr),
    .go_i     (du_done && (state_q == CTL_CONV)),
    .cfg_i    (cfg),
    .strobe_o (strobe_o),
    .char_o   (text_char_o),
    .last_o   (last_o)
  );

endmodule

// ----- hdl/itf_checker.sv -----
// Port-level checks for integer_text_formatter_core, attached by bind.
// Depends only on the top level's ports.
module itf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe_o,
  input logic last_o
);

  // Characters only flow while a request is in progress
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy)
    else $error("character strobe while not busy");

  // The last mark rides on a character
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last mark without a character");

  // An accepted request keeps the block busy and emits nothing at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !strobe_o))
    else $error("accepted request did not start conversion");

  // Busy ends only right after the final character
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(strobe_o && last_o))
    else $error("busy dropped before the final character");

endmodule

bind integer_text_formatter_core itf_checker u_itf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .last_o   (last_o)
);
